// ----- sv/tfc_pkg.sv -----
package tfc_pkg;

	localparam int F = 16;
	localparam int WIN_W = 17;
	localparam int ONE_INT = 1 << F;
	localparam int MIN_DEN = (ONE_INT + 9999) / 10000;
	localparam int DEN_W = WIN_W + 8;
	localparam int NUM_W = ((F > WIN_W) ? F : WIN_W) + 9;
	localparam int LAT = F + 4;
	localparam logic [F:0] ONE_Q = (F + 1)'(ONE_INT);

	localparam logic [1:0] FMT_RGB = 2'd0;
	localparam logic [1:0] FMT_BGR = 2'd1;
	localparam logic [1:0] FMT_GRAY = 2'd2;

	localparam logic [2:0] MODE_PASS = 3'd0;
	localparam logic [2:0] MODE_GRAY = 3'd1;
	localparam logic [2:0] MODE_WHITE = 3'd2;
	localparam logic [2:0] MODE_BLACK = 3'd3;
	localparam logic [2:0] MODE_IRON = 3'd4;
	localparam logic [2:0] MODE_RAINBOW = 3'd5;
	localparam logic [2:0] MODE_ARCTIC = 3'd6;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;
	localparam logic [1:0] REG_WIN_LOW = 2'd2;
	localparam logic [1:0] REG_WIN_HIGH = 2'd3;

	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_out_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] intensity;
	} side_t;

	function automatic logic [7:0] ramp(input logic [F:0] f);
		logic [F+8:0] p;
		p = {f, 8'b0} - {8'b0, f};
		return p[F+7:F];
	endfunction

	// floor(base + slope * rem / quarter), clamped at zero
	function automatic logic [7:0] seg_chan(input longint base, input longint slope,
			input logic [F-2:0] rem);
		longint acc;
		acc = (base <<< (F - 2)) + slope * longint'(rem);
		if (acc < 0) begin
			acc = 0;
		end
		return 8'(acc >>> (F - 2));
	endfunction

	function automatic logic [7:0] arctic_chan(input longint base, input longint slope,
			input logic [F:0] n);
		longint acc;
		acc = (base <<< F) + slope * longint'(n);
		return 8'(acc >>> F);
	endfunction

endpackage

// ----- sv/tfc_norm_div.sv -----
module tfc_norm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [tfc_pkg::NUM_W-1:0] num,
	input  logic [tfc_pkg::DEN_W-1:0]     den,
	input  tfc_pkg::side_t                in_side,
	output logic                          out_valid,
	output logic [tfc_pkg::F:0]           n,
	output tfc_pkg::side_t                out_side
);
	import tfc_pkg::*;

	logic              v_s [F+1];
	logic              sat_s [F+1];
	logic [DEN_W-1:0]  rem_s [F+1];
	logic [F-1:0]      q_s [F+1];
	side_t             side_s [F+1];

	// classify: zero, saturated, or divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		q_s[0] <= '0;
		if (num <= 0) begin
			sat_s[0] <= 1'b0;
			rem_s[0] <= '0;
		end else if ($unsigned(num) >= NUM_W'(den)) begin
			sat_s[0] <= 1'b1;
			rem_s[0] <= '0;
		end else begin
			sat_s[0] <= 1'b0;
			rem_s[0] <= num[DEN_W-1:0];
		end
	end

	for (genvar k = 0; k < F; k++) begin : g_div
		logic [DEN_W:0] r2;
		logic           take;
		assign r2 = {rem_s[k], 1'b0};
		assign take = (r2 >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			sat_s[k+1] <= sat_s[k];
			q_s[k+1] <= {q_s[k][F-2:0], take};
			if (take) begin
				rem_s[k+1] <= DEN_W'(r2 - {1'b0, den});
			end else begin
				rem_s[k+1] <= r2[DEN_W-1:0];
			end
		end
	end

	assign out_valid = v_s[F];
	assign n = sat_s[F] ? ONE_Q : {1'b0, q_s[F]};
	assign out_side = side_s[F];

endmodule

// ----- sv/thermal_false_color_pixel_mapper_core.sv -----
// A started pixel passes stage 1, stage 2, the divider and the palette register before done.
// Throughput: one pixel per cycle; busy stays low.
// The normalization divide is a 16-stage restoring pipeline, one quotient bit per stage.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (arst_n, async): pipeline emptied, registers back to RGB24, passthrough, window 0..1.
module thermal_false_color_pixel_mapper_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tfc_pkg::pix_in_t            request,
	output logic                        done,
	output tfc_pkg::pix_out_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [tfc_pkg::WIN_W-1:0]   cfg_data
);
	import tfc_pkg::*;

	logic [1:0]       fmt_q;
	logic [2:0]       mode_q;
	logic [WIN_W-1:0] lo_q;
	logic [WIN_W-1:0] hi_q;
	logic [DEN_W-1:0] dprod_q;
	logic [DEN_W-1:0] lo255_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB;
			mode_q <= MODE_PASS;
			lo_q <= '0;
			hi_q <= WIN_W'(ONE_INT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FORMAT:   fmt_q <= cfg_data[1:0];
				REG_MODE:     mode_q <= cfg_data[2:0];
				REG_WIN_LOW:  lo_q <= cfg_data;
				REG_WIN_HIGH: hi_q <= cfg_data;
			endcase
		end
	end

	logic signed [WIN_W:0] den_raw;
	logic [WIN_W-1:0]      den_cl;
	assign den_raw = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
	assign den_cl = (den_raw < $signed((WIN_W + 1)'(MIN_DEN))) ? WIN_W'(MIN_DEN)
		: den_raw[WIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dprod_q <= '0;
			lo255_q <= '0;
		end else begin
			dprod_q <= {den_cl, 8'b0} - {8'b0, den_cl};
			lo255_q <= {lo_q, 8'b0} - {8'b0, lo_q};
		end
	end

	// stage 1: byte order and luma sum
	logic [7:0]  r_in, g_in, b_in;
	logic        gray_in;
	logic        v_s1;
	logic        gray_s1;
	logic [25:0] luma_s1;
	side_t       side_s1;

	always_comb begin
		gray_in = 1'b0;
		g_in = request.byte_one;
		r_in = request.byte_zero;
		b_in = request.byte_two;
		if (fmt_q == FMT_BGR) begin
			r_in = request.byte_two;
			b_in = request.byte_zero;
		end else if (fmt_q != FMT_RGB) begin
			gray_in = 1'b1;
			r_in = request.byte_zero;
			g_in = request.byte_zero;
			b_in = request.byte_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		gray_s1 <= gray_in;
		luma_s1 <= 26'd13933 * 26'(r_in) + 26'd46871 * 26'(g_in) + 26'd4732 * 26'(b_in);
		side_s1 <= '{r: r_in, g: g_in, b: b_in, intensity: r_in};
	end

	// stage 2: intensity and window numerator
	logic                    v_s2;
	logic signed [NUM_W-1:0] num_s2;
	side_t                   side_s2;
	logic [7:0]              inten;
	assign inten = gray_s1 ? side_s1.intensity : luma_s1[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2 <= $signed(NUM_W'({inten, F'(0)})) - $signed(NUM_W'(lo255_q));
		side_s2 <= '{r: side_s1.r, g: side_s1.g, b: side_s1.b, intensity: inten};
	end

	logic       v_dv;
	logic [F:0] n_dv;
	side_t      side_dv;

	tfc_norm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (num_s2),
		.den       (dprod_q),
		.in_side   (side_s2),
		.out_valid (v_dv),
		.n         (n_dv),
		.out_side  (side_dv)
	);

	// palette stage
	logic [2:0]   seg;
	logic [F-2:0] rem;
	logic [F+2:0] six;
	logic [2:0]   region;
	logic [F-1:0] frac;
	logic [7:0]   up, down, pr, pg, pb;
	logic         v_p1;
	pix_out_t     out_p1;

	always_comb begin
		seg = n_dv[F:F-2];
		if (seg > 3'd3) begin
			seg = 3'd3;
		end
		rem = (F - 1)'(n_dv - ((F + 1)'(seg) << (F - 2)));
		six = {n_dv, 2'b0} + {1'b0, n_dv, 1'b0};
		region = six[F+2:F];
		frac = six[F-1:0];
		up = ramp({1'b0, frac});
		down = ramp(ONE_Q - {1'b0, frac});
		pr = side_dv.r;
		pg = side_dv.g;
		pb = side_dv.b;
		unique case (mode_q)
			MODE_GRAY: begin
				pr = side_dv.intensity;
				pg = side_dv.intensity;
				pb = side_dv.intensity;
			end
			MODE_WHITE: begin
				pr = ramp(n_dv);
				pg = pr;
				pb = pr;
			end
			MODE_BLACK: begin
				pr = ramp(ONE_Q - n_dv);
				pg = pr;
				pb = pr;
			end
			MODE_IRON: begin
				unique case (seg)
					3'd0: begin
						pr = seg_chan(0, 30, rem);
						pg = 8'd0;
						pb = seg_chan(80, 60, rem);
					end
					3'd1: begin
						pr = seg_chan(30, 90, rem);
						pg = seg_chan(10, 30, rem);
						pb = seg_chan(140, -80, rem);
					end
					3'd2: begin
						pr = seg_chan(120, 90, rem);
						pg = seg_chan(40, 80, rem);
						pb = seg_chan(60, -40, rem);
					end
					default: begin
						pr = seg_chan(210, 45, rem);
						pg = seg_chan(120, 110, rem);
						pb = seg_chan(20, 35, rem);
					end
				endcase
			end
			MODE_RAINBOW: begin
				unique case (region)
					3'd1: begin pr = down;  pg = 8'd255; pb = 8'd0;   end
					3'd2: begin pr = 8'd0;  pg = 8'd255; pb = up;     end
					3'd3: begin pr = 8'd0;  pg = down;   pb = 8'd255; end
					3'd4: begin pr = up;    pg = 8'd0;   pb = 8'd255; end
					3'd5: begin pr = 8'd255; pg = 8'd0;  pb = down;   end
					// first sextant, and exactly 1.0 wrapping to red
					default: begin pr = 8'd255; pg = up; pb = 8'd0; end
				endcase
			end
			MODE_ARCTIC: begin
				pr = arctic_chan(40, 170, n_dv);
				pg = arctic_chan(70, 140, n_dv);
				pb = arctic_chan(120, 135, n_dv);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
		end else begin
			v_p1 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		out_p1 <= '{red: pr, green: pg, blue: pb};
	end

	assign done = v_p1;
	assign result = out_p1;

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without matching request");

	a_norm_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_dv |-> (n_dv <= ONE_Q))
		else $error("normalized value above one");

	a_div_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ##(F + 1) v_dv)
		else $error("item lost in divider");

endmodule

// ----- bench/thermal_pixel_checker.sv -----
`timescale 1ns / 100ps

module thermal_pixel_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  tfc_pkg::pix_in_t          request,
	input  logic                      done,
	input  tfc_pkg::pix_out_t         result,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [tfc_pkg::WIN_W-1:0] cfg_data,
	output int                        fails,
	output int                        pending
);
	import tfc_pkg::*;

	localparam longint ONE = 64'd65536;
	localparam longint QUARTER = ONE / 4;

	logic [1:0]       fmt_q;
	logic [2:0]       mode_q;
	logic [WIN_W-1:0] lo_q;
	logic [WIN_W-1:0] hi_q;
	pix_out_t         color_q[$];

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	function automatic longint window_pos(input longint level);
		longint den;
		longint num;
		longint q;
		den = longint'(hi_q) - longint'(lo_q);
		if (den < MIN_DEN) begin
			den = MIN_DEN;
		end
		num = level * ONE - longint'(lo_q) * 255;
		if (num <= 0) begin
			return 0;
		end
		q = (num * ONE) / (den * 255);
		return (q > ONE) ? ONE : q;
	endfunction

	function automatic logic [7:0] quarter_chan(input longint base, input longint slope,
			input longint rem);
		longint num;
		num = base * QUARTER + slope * rem;
		if (num < 0) begin
			num = 0;
		end
		return 8'(num / QUARTER);
	endfunction

	function automatic logic [7:0] scale255(input longint f);
		return 8'((f * 255) >>> 16);
	endfunction

	function automatic logic [7:0] cold_chan(input longint base, input longint slope,
			input longint n);
		return 8'((base * ONE + slope * n) >>> 16);
	endfunction

	function automatic pix_out_t map_pixel(input pix_in_t px);
		pix_out_t  c;
		logic [7:0] lvl;
		longint    n;
		longint    seg;
		longint    rem;
		longint    six;
		longint    f;
		logic [7:0] up;
		logic [7:0] down;
		if (fmt_q == FMT_RGB || fmt_q == FMT_BGR) begin
			c.green = px.byte_one;
			if (fmt_q == FMT_RGB) begin
				c.red = px.byte_zero;
				c.blue = px.byte_two;
			end else begin
				c.red = px.byte_two;
				c.blue = px.byte_zero;
			end
			lvl = 8'((13933 * longint'(c.red) + 46871 * longint'(c.green)
				+ 4732 * longint'(c.blue)) >>> 16);
		end else begin
			lvl = px.byte_zero;
			c = '{lvl, lvl, lvl};
		end
		n = window_pos(longint'(lvl));
		case (mode_q)
			MODE_GRAY: begin
				c = '{lvl, lvl, lvl};
			end
			MODE_WHITE: begin
				c = '{scale255(n), scale255(n), scale255(n)};
			end
			MODE_BLACK: begin
				c = '{scale255(ONE - n), scale255(ONE - n), scale255(ONE - n)};
			end
			MODE_IRON: begin
				seg = n >>> 14;
				if (seg > 3) begin
					seg = 3;
				end
				rem = n - seg * QUARTER;
				case (seg)
					0: c = '{quarter_chan(0, 30, rem), 8'd0, quarter_chan(80, 60, rem)};
					1: c = '{quarter_chan(30, 90, rem), quarter_chan(10, 30, rem),
						quarter_chan(140, -80, rem)};
					2: c = '{quarter_chan(120, 90, rem), quarter_chan(40, 80, rem),
						quarter_chan(60, -40, rem)};
					default: c = '{quarter_chan(210, 45, rem), quarter_chan(120, 110, rem),
						quarter_chan(20, 35, rem)};
				endcase
			end
			MODE_RAINBOW: begin
				six = n * 6;
				f = six & (ONE - 1);
				up = scale255(f);
				down = scale255(ONE - f);
				case ((six >>> 16) % 6)
					0: c = '{8'd255, up, 8'd0};
					1: c = '{down, 8'd255, 8'd0};
					2: c = '{8'd0, 8'd255, up};
					3: c = '{8'd0, down, 8'd255};
					4: c = '{up, 8'd0, 8'd255};
					default: c = '{8'd255, 8'd0, down};
				endcase
			end
			MODE_ARCTIC: begin
				c = '{cold_chan(40, 170, n), cold_chan(70, 140, n), cold_chan(120, 135, n)};
			end
			default: begin
			end
		endcase
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			fmt_q <= FMT_RGB;
			mode_q <= MODE_PASS;
			lo_q <= '0;
			hi_q <= WIN_W'(ONE_INT);
			color_q.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (color_q.size() == 0) begin
					report("result with no request outstanding", 1, 0);
				end else begin
					want = color_q.pop_front();
					if (result.red !== want.red) report("red", result.red, want.red);
					if (result.green !== want.green) report("green", result.green, want.green);
					if (result.blue !== want.blue) report("blue", result.blue, want.blue);
				end
			end
			if (start && !busy) begin
				color_q.push_back(map_pixel(request));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FORMAT: fmt_q <= cfg_data[1:0];
					REG_MODE: mode_q <= cfg_data[2:0];
					REG_WIN_LOW: lo_q <= cfg_data;
					REG_WIN_HIGH: hi_q <= cfg_data;
					default: begin
					end
				endcase
			end
			pending <= color_q.size();
		end
	end
endmodule

// ----- bench/tb_thermal_false_color_pixel_mapper_core.sv -----
`timescale 1ns / 100ps

module tb_thermal_false_color_pixel_mapper_core;
	import tfc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 1100;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	pix_in_t          request;
	logic             done;
	pix_out_t         result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [WIN_W-1:0] cfg_data;
	int               fails;
	int               pending;
	int               idle_pct;
	int               sent;
	int               quiet_cycles;

	thermal_false_color_pixel_mapper_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	thermal_pixel_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fails(fails), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [WIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LAT + 4) @(negedge clk);
	endtask

	task automatic setup(input logic [1:0] fmt, input logic [2:0] mode,
			input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
		drain();
		write_reg(REG_FORMAT, WIN_W'(fmt));
		write_reg(REG_MODE, WIN_W'(mode));
		write_reg(REG_WIN_LOW, lo);
		write_reg(REG_WIN_HIGH, hi);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_pixel(input pix_in_t px);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		request <= px;
		do @(posedge clk); while (busy);
		@(negedge clk);
		sent++;
		if (sent < ITEM_TARGET / 3) idle_pct = 21;
		else if (sent < 2 * ITEM_TARGET / 3) idle_pct = 50;
		else idle_pct = 0;
	endtask

	function automatic logic [WIN_W-1:0] pick_window();
		case ($urandom_range(5))
			0: return '0;
			1: return WIN_W'(ONE_INT);
			2: return '1;
			default: return WIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic edge_pixels();
		send_pixel('{8'h00, 8'h00, 8'h00});
		send_pixel('{8'hFF, 8'hFF, 8'hFF});
		send_pixel('{8'hFF, 8'h00, 8'h80});
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_data = '0;
		quiet_cycles = 0;
		sent = 0;
		idle_pct = 21;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset config, then each mode; gray 255 hits ironbow/rainbow at full scale
		edge_pixels();
		setup(FMT_GRAY, MODE_PASS, '0, WIN_W'(ONE_INT));
		edge_pixels();
		setup(FMT_BGR, MODE_GRAY, '0, WIN_W'(ONE_INT));
		edge_pixels();
		setup(FMT_GRAY, MODE_WHITE, WIN_W'(30000), WIN_W'(30000));
		edge_pixels();
		setup(FMT_RGB, MODE_BLACK, WIN_W'(10000), WIN_W'(50000));
		edge_pixels();
		setup(FMT_GRAY, MODE_IRON, '0, WIN_W'(ONE_INT));
		edge_pixels();
		setup(FMT_GRAY, MODE_RAINBOW, '0, WIN_W'(ONE_INT));
		edge_pixels();
		setup(2'd3, MODE_ARCTIC, WIN_W'(40000), WIN_W'(20000));
		edge_pixels();
		setup(FMT_BGR, 3'd7, '1, '1);
		edge_pixels();

		while (sent < ITEM_TARGET) begin
			setup(2'($urandom_range(3)), 3'($urandom_range(7)), pick_window(), pick_window());
			repeat ($urandom_range(10, 40)) begin
				send_pixel('{pick_byte(), pick_byte(), pick_byte()});
			end
		end
		start <= 1'b0;
		drain();

		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
